// ----- src/gpcf_pkg.sv -----
`timescale 1ns / 1ps
package gpcf_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] OP_CALIB   = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_POSE    = 2'd2;
  localparam logic [1:0] OP_POLL    = 2'd3;

  // register indexes
  localparam logic [2:0] REG_DIST_GATE = 3'd0;
  localparam logic [2:0] REG_HEAD_GATE = 3'd1;
  localparam logic [2:0] REG_HEAD_GAIN = 3'd2;
  localparam logic [2:0] REG_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_NEGATE    = 3'd4;

  // register reset values
  localparam logic [30:0] DIST_GATE_RST = 31'd19661;
  localparam logic [13:0] HEAD_GATE_RST = 14'd1430;
  localparam logic [15:0] HEAD_GAIN_RST = 16'd6554;
  localparam logic [15:0] TIMEOUT_RST   = 16'd500;

  // fixed-point constants
  localparam int BIAS_TARGET = 256;
  localparam logic signed [19:0] HEAD_PI     = 20'sd12868;
  localparam logic signed [19:0] HEAD_TWO_PI = 20'sd25736;
  localparam logic [31:0] RATE_K = 32'd1228166;
  localparam logic signed [23:0] OFFSET_MAX = 24'sd8388607;

  localparam int IN_W  = 152;
  localparam int OUT_W = 184;

endpackage

// ----- src/gyro_pose_complementary_fusion.sv -----
`timescale 1ns / 1ps
// throughput: one item at a time; a new item is taken once the result is transferred
// all multiplications run through one shared 32x32 multiplier; both heading wraps share one wrap step
// reset (rst, synchronous): clears pose, calibration, window, counters and registers
module gyro_pose_complementary_fusion
  import gpcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  // gyro_rate, interval_us, pos_x, pos_y, host_heading, now_ms
  input  logic [IN_W-1:0]   s_tdata,
  // operation
  input  logic [1:0]        s_tuser,
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // est_x, est_y, est_heading, frame_accepted, calibration_done, link_lost,
  // position_reject_count, heading_reject_count, host_frame_count
  output logic [OUT_W-1:0]  m_tdata,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_CALIB = 5'd2;
  localparam logic [4:0] S_P1    = 5'd3;
  localparam logic [4:0] S_P2    = 5'd4;
  localparam logic [4:0] S_P3    = 5'd5;
  localparam logic [4:0] S_P4    = 5'd6;
  localparam logic [4:0] S_PWRAP = 5'd7;
  localparam logic [4:0] S_D1    = 5'd8;
  localparam logic [4:0] S_D2    = 5'd9;
  localparam logic [4:0] S_D3    = 5'd10;
  localparam logic [4:0] S_D4    = 5'd11;
  localparam logic [4:0] S_WIN   = 5'd12;
  localparam logic [4:0] S_EWRAP = 5'd13;
  localparam logic [4:0] S_H1    = 5'd14;
  localparam logic [4:0] S_H2    = 5'd15;
  localparam logic [4:0] S_MED   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  // configuration registers
  logic [30:0] distance_gate;
  logic [13:0] heading_gate;
  logic [15:0] heading_gain;
  logic [15:0] link_timeout_ms;
  logic        gyro_negate;

  // block state
  logic [4:0]         state;
  logic signed [31:0] fused_x, fused_y;
  logic signed [15:0] fused_heading;
  logic signed [23:0] bias_offset;
  logic signed [31:0] bias_sum;
  logic [8:0]         bias_samples;
  logic               seen_host;
  logic [31:0]        last_host_ms;
  logic signed [31:0] win_x [3];
  logic signed [31:0] win_y [3];
  logic [1:0]         window_slot, window_fill;
  logic [31:0]        position_rejects, heading_rejects, host_frames;
  logic               accepted;

  // latched item
  logic [1:0]         op_r;
  logic signed [23:0] rate_r;
  logic [15:0]        ivl_r;
  logic signed [31:0] px_r, py_r;
  logic signed [14:0] hh_r;
  logic [31:0]        now_r;

  // work registers
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [63:0]        acc;
  logic [19:0]        mhi;
  logic               rsign;
  logic [24:0]        rmag;
  logic [31:0]        ax, ay;
  logic signed [19:0] hw;
  logic [13:0]        aerr;
  logic               errneg;

  logic out_valid;
  logic [OUT_W-1:0] out_data;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_gate   <= DIST_GATE_RST;
      heading_gate    <= HEAD_GATE_RST;
      heading_gain    <= HEAD_GAIN_RST;
      link_timeout_ms <= TIMEOUT_RST;
      gyro_negate     <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_DIST_GATE: distance_gate   <= pwdata[30:0];
        REG_HEAD_GATE: heading_gate    <= pwdata[13:0];
        REG_HEAD_GAIN: heading_gain    <= pwdata[15:0];
        REG_TIMEOUT:   link_timeout_ms <= pwdata[15:0];
        REG_NEGATE:    gyro_negate     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DIST_GATE: prdata = {1'b0, distance_gate};
      REG_HEAD_GATE: prdata = {18'd0, heading_gate};
      REG_HEAD_GAIN: prdata = {16'd0, heading_gain};
      REG_TIMEOUT:   prdata = {16'd0, link_timeout_ms};
      REG_NEGATE:    prdata = {31'd0, gyro_negate};
      default:       prdata = 32'd0;
    endcase
  end

  // handshake
  assign s_tready = (state == S_IDLE) && !out_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // shared multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_P1: begin mul_a = {7'd0, rmag}; mul_b = {16'd0, ivl_r}; end
      S_P2: begin mul_a = {11'd0, prod[20:0]}; mul_b = RATE_K; end
      S_P3: begin mul_a = {12'd0, mhi}; mul_b = RATE_K; end
      S_D1: begin mul_a = ax; mul_b = ax; end
      S_D2: begin mul_a = ay; mul_b = ay; end
      S_D3: begin mul_a = {1'b0, distance_gate}; mul_b = {1'b0, distance_gate}; end
      S_H1: begin mul_a = {18'd0, aerr}; mul_b = {16'd0, heading_gain}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod <= mul_a * mul_b;

  // median of three
  function automatic logic signed [31:0] med3(input logic signed [31:0] a0,
                                              input logic signed [31:0] b0,
                                              input logic signed [31:0] c0);
    logic signed [31:0] a, b, c, t;
    a = a0; b = b0; c = c0;
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin b = c; end
    if (a > b) begin b = a; end
    return b;
  endfunction

  // combinational helpers
  logic signed [25:0] r_sum;
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [32:0]        cal_mag, cal_q;
  logic [63:0]        p_tot, p_rnd;
  logic [17:0]        p_q;
  logic [31:0]        h_rnd;
  logic [14:0]        h_q;
  logic               w_hi, w_lo;
  logic [1:0]         slot_eff;
  logic signed [31:0] med_x, med_y;

  always_comb begin
    r_sum = 26'(rate_r) + 26'(bias_offset);
    if (gyro_negate) r_sum = -r_sum;
    dx  = 33'(px_r) - 33'(fused_x);
    dy  = 33'(py_r) - 33'(fused_y);
    adx = dx[32] ? 33'(-dx) : 33'(dx);
    ady = dy[32] ? 33'(-dy) : 33'(dy);
    cal_mag = bias_sum[31] ? 33'(-33'(bias_sum)) : 33'(bias_sum);
    cal_q   = (cal_mag + 33'(BIAS_TARGET / 2)) / BIAS_TARGET;
    p_tot = {22'd0, acc[41:0]} + {2'd0, prod[40:0], 21'd0};
    p_rnd = p_tot + (64'd1 << 45);
    p_q   = p_rnd[63:46];
    h_rnd = prod[31:0] + 32'd32768;
    h_q   = h_rnd[30:16];
    w_hi  = hw > HEAD_PI;
    w_lo  = hw <= -HEAD_PI;
    slot_eff = (window_slot == 2'd3) ? 2'd0 : window_slot;
    case (window_fill)
      2'd1:    begin med_x = win_x[0]; med_y = win_y[0]; end
      2'd2:    begin med_x = win_x[1]; med_y = win_y[1]; end
      default: begin
        med_x = med3(win_x[0], win_x[1], win_x[2]);
        med_y = med3(win_y[0], win_y[1], win_y[2]);
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      fused_x          <= '0;
      fused_y          <= '0;
      fused_heading    <= '0;
      bias_offset      <= '0;
      bias_sum         <= '0;
      bias_samples     <= '0;
      seen_host        <= 1'b0;
      last_host_ms     <= '0;
      window_slot      <= '0;
      window_fill      <= '0;
      position_rejects <= '0;
      heading_rejects  <= '0;
      host_frames      <= '0;
      accepted         <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win_x[i] <= '0;
        win_y[i] <= '0;
      end
    end else begin
      if (out_valid && m_tready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            op_r     <= s_tuser;
            rate_r   <= s_tdata[23:0];
            ivl_r    <= s_tdata[39:24];
            px_r     <= s_tdata[71:40];
            py_r     <= s_tdata[103:72];
            hh_r     <= s_tdata[118:104];
            now_r    <= s_tdata[150:119];
            accepted <= 1'b0;
            state    <= S_START;
          end
        end
        S_START: begin
          unique case (op_r)
            OP_CALIB: begin
              if (32'(bias_samples) < BIAS_TARGET) begin
                bias_sum     <= bias_sum + 32'(rate_r);
                bias_samples <= bias_samples + 9'd1;
              end
              state <= S_CALIB;
            end
            OP_PREDICT: begin
              rsign <= r_sum[25];
              rmag  <= r_sum[25] ? 25'(-r_sum) : 25'(r_sum);
              state <= S_P1;
            end
            OP_POSE: begin
              host_frames  <= host_frames + 32'd1;
              last_host_ms <= now_r;
              ax <= adx[31:0];
              ay <= ady[31:0];
              if (!seen_host) begin
                state <= S_WIN;
              end else if (adx > {2'd0, distance_gate} || ady > {2'd0, distance_gate}) begin
                position_rejects <= position_rejects + 32'd1;
                state <= S_DONE;
              end else begin
                state <= S_D1;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_CALIB: begin
          if (32'(bias_samples) >= BIAS_TARGET) begin
            if (bias_sum[31])
              bias_offset <= (cal_q > 33'(OFFSET_MAX)) ? OFFSET_MAX : cal_q[23:0];
            else
              bias_offset <= -cal_q[23:0];
          end
          state <= S_DONE;
        end
        // heading increment: |r| * interval * k, then round by 2^46
        S_P1: state <= S_P2;
        S_P2: begin
          mhi   <= prod[40:21];
          state <= S_P3;
        end
        S_P3: begin
          acc   <= prod;
          state <= S_P4;
        end
        S_P4: begin
          hw    <= 20'(fused_heading) + (rsign ? -20'(p_q) : 20'(p_q));
          state <= S_PWRAP;
        end
        // wrap heading sum into (-pi, pi], one step a cycle
        S_PWRAP: begin
          if (w_hi) hw <= hw - HEAD_TWO_PI;
          else if (w_lo) hw <= hw + HEAD_TWO_PI;
          else begin
            fused_heading <= hw[15:0];
            state <= (op_r == OP_POSE) ? S_MED : S_DONE;
          end
        end
        // squared distance gate
        S_D1: state <= S_D2;
        S_D2: begin
          acc   <= prod;
          state <= S_D3;
        end
        S_D3: begin
          acc   <= acc + prod;
          state <= S_D4;
        end
        S_D4: begin
          if (acc > prod) begin
            position_rejects <= position_rejects + 32'd1;
            state <= S_DONE;
          end else begin
            state <= S_WIN;
          end
        end
        // store frame in the median window
        S_WIN: begin
          win_x[slot_eff] <= px_r;
          win_y[slot_eff] <= py_r;
          window_slot <= (slot_eff == 2'd2) ? 2'd0 : slot_eff + 2'd1;
          if (window_fill < 2'd3) window_fill <= window_fill + 2'd1;
          hw    <= 20'(hh_r) - 20'(fused_heading);
          state <= S_EWRAP;
        end
        // wrap heading error, then apply heading gate
        S_EWRAP: begin
          if (w_hi) hw <= hw - HEAD_TWO_PI;
          else if (w_lo) hw <= hw + HEAD_TWO_PI;
          else begin
            errneg <= hw[19];
            aerr   <= hw[19] ? 14'(-hw) : hw[13:0];
            if (seen_host && (hw[19] ? 14'(-hw) : hw[13:0]) > heading_gate) begin
              heading_rejects <= heading_rejects + 32'd1;
              state <= S_MED;
            end else begin
              state <= S_H1;
            end
          end
        end
        S_H1: state <= S_H2;
        S_H2: begin
          hw    <= 20'(fused_heading) + (errneg ? -20'(h_q) : 20'(h_q));
          state <= S_PWRAP;
        end
        S_MED: begin
          fused_x   <= med_x;
          fused_y   <= med_y;
          seen_host <= 1'b1;
          accepted  <= 1'b1;
          state     <= S_DONE;
        end
        // result register
        S_DONE: begin
          out_data <= {5'd0, host_frames, heading_rejects, position_rejects,
                       seen_host && ((now_r - last_host_ms) > 32'(link_timeout_ms)),
                       32'(bias_samples) >= BIAS_TARGET, accepted,
                       fused_heading, fused_y, fused_x};
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/gpcf_checker.sv -----
`timescale 1ns / 1ps
module gpcf_props
  import gpcf_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // a waiting result holds until transferred
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no new item while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while result pending");

  // an accepted item blocks further input next cycle
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !m_tvalid)
    else $error("input taken back to back");

  // a result only follows a busy period
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared from idle");

endmodule

bind gyro_pose_complementary_fusion gpcf_props u_gpcf_props (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
